FILE: rtl/core/pcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants, codes and tables of the phase current Clarke/Park block.
// ----------------------------------------------------------------------------
package pcp_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	// CORDIC datapath widths: vector components and residual angle.
	localparam int CW    = 20;
	localparam int ITERS = FRAC_W;

	// Root width: the radicand is below 2^47, so the root stays below 2^24.
	localparam int ROOT_W = 24;
	localparam int REM_W  = 48;
	localparam int SUM_W  = 31;

	localparam logic signed [17:0] K_THIRD     = 18'sd21845;
	localparam logic signed [17:0] K_INV_SQRT3 = 18'sd37837;
	localparam logic signed [17:0] K_TWO_SQRT3 = 18'sd75674;

	localparam logic signed [CW-1:0] K_TWO_PI  = 20'sd411774;
	localparam logic signed [CW-1:0] K_PI      = 20'sd205887;
	localparam logic signed [CW-1:0] K_HALF_PI = 20'sd102943;
	localparam logic signed [CW-1:0] K_GAIN    = 20'sd39796;

	localparam logic [SUM_W-1:0] MAX_POS = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		REG_OFFSET_A    = 2'd0,
		REG_OFFSET_B    = 2'd1,
		REG_OFFSET_C    = 2'd2,
		REG_DRIVER_MODE = 2'd3
	} cfg_reg_t;

	localparam logic [1:0] MODE_BLDC    = 2'd0;
	localparam logic [1:0] MODE_STEPPER = 2'd1;
	localparam logic [1:0] MODE_HYBRID  = 2'd2;

	// Arctangent of 2^-i in radians, signed Q4.16, truncated.
	function automatic logic signed [CW-1:0] atan_c(input int i);
		logic signed [CW-1:0] v;
		case (i)
			0:       v = 20'sd51471;
			1:       v = 20'sd30385;
			2:       v = 20'sd16054;
			3:       v = 20'sd8149;
			4:       v = 20'sd4090;
			5:       v = 20'sd2047;
			6:       v = 20'sd1023;
			7:       v = 20'sd511;
			8:       v = 20'sd255;
			9:       v = 20'sd127;
			10:      v = 20'sd63;
			11:      v = 20'sd31;
			12:      v = 20'sd15;
			13:      v = 20'sd7;
			14:      v = 20'sd3;
			15:      v = 20'sd1;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/pcp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, then a stage that
// negates both results for angles folded by pi.
// ----------------------------------------------------------------------------
module pcp_cordic (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [pcp_pkg::CW-1:0]  ang,
	input  logic                           flip,
	output logic signed [pcp_pkg::CW-1:0]  cos_o,
	output logic signed [pcp_pkg::CW-1:0]  sin_o
);
	import pcp_pkg::*;

	logic signed [CW-1:0] x_s [0:ITERS-1];
	logic signed [CW-1:0] y_s [0:ITERS-1];
	logic signed [CW-1:0] r_s [0:ITERS-1];
	logic                 flip_s [0:ITERS-1];

	logic signed [CW-1:0] x_in [0:ITERS-1];
	logic signed [CW-1:0] y_in [0:ITERS-1];
	logic signed [CW-1:0] r_in [0:ITERS-1];
	logic                 f_in [0:ITERS-1];

	always_comb begin
		x_in[0] = K_GAIN;
		y_in[0] = '0;
		r_in[0] = ang;
		f_in[0] = flip;
		for (int i = 1; i < ITERS; i++) begin
			x_in[i] = x_s[i-1];
			y_in[i] = y_s[i-1];
			r_in[i] = r_s[i-1];
			f_in[i] = flip_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ITERS; i++) begin
				if (r_in[i] >= 0) begin
					x_s[i] <= x_in[i] - (y_in[i] >>> i);
					y_s[i] <= y_in[i] + (x_in[i] >>> i);
					r_s[i] <= r_in[i] - atan_c(i);
				end else begin
					x_s[i] <= x_in[i] + (y_in[i] >>> i);
					y_s[i] <= y_in[i] - (x_in[i] >>> i);
					r_s[i] <= r_in[i] + atan_c(i);
				end
				flip_s[i] <= f_in[i];
			end
			cos_o <= flip_s[ITERS-1] ? -x_s[ITERS-1] : x_s[ITERS-1];
			sin_o <= flip_s[ITERS-1] ? -y_s[ITERS-1] : y_s[ITERS-1];
		end
	end

endmodule

FILE: rtl/core/pcp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_sqrt
// Pipelined digit-by-digit square root of s * 2^16, one root bit per stage.
// ----------------------------------------------------------------------------
module pcp_sqrt (
	input  logic                            clk,
	input  logic                            en,
	input  logic [pcp_pkg::SUM_W-1:0]       s_in,
	output logic [pcp_pkg::ROOT_W-1:0]      root_o
);
	import pcp_pkg::*;

	logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];

	logic [REM_W-1:0]  rem_in  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_in [0:ROOT_W-1];
	logic [REM_W-1:0]  sub_c   [0:ROOT_W-1];

	// The remainder holds radicand minus root squared; setting bit i adds
	// root * 2^(i+1) + 2^(2i) to the square.
	always_comb begin
		rem_in[0]  = {1'b0, s_in, {FRAC_W{1'b0}}};
		root_in[0] = '0;
		for (int j = 1; j < ROOT_W; j++) begin
			rem_in[j]  = rem_s[j-1];
			root_in[j] = root_s[j-1];
		end
		for (int j = 0; j < ROOT_W; j++) begin
			sub_c[j] = ({{(REM_W-ROOT_W){1'b0}}, root_in[j]} << (ROOT_W - j))
				+ ({{(REM_W-1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - j)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ROOT_W; j++) begin
				if (rem_in[j] >= sub_c[j]) begin
					rem_s[j]  <= rem_in[j] - sub_c[j];
					root_s[j] <= root_in[j] | ({{(ROOT_W-1){1'b0}}, 1'b1} << (ROOT_W - 1 - j));
				end else begin
					rem_s[j]  <= rem_in[j];
					root_s[j] <= root_in[j];
				end
			end
		end
	end

	assign root_o = root_s[ROOT_W-1];

endmodule

FILE: rtl/core/phase_current_clarke_park.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_current_clarke_park
// Offset removal, Clarke transform by driver mode, CORDIC sine/cosine, Park
// transform and signed current magnitude, as one 33-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata: raw_a, raw_b, raw_c, elec_angle; tuser: angle_valid
//  m_axis   | out       | tdata: i_alpha, i_beta, i_d, i_q, dc_current
//  cfg      | in        | offset_a, offset_b, offset_c, driver_mode
//
// One transfer is taken per cycle while the output is not stalled. The pipeline
// length is set by the magnitude path: eight stages up to the sum of squares,
// the 24 root stages and the output register. Reset clears the stage valid
// bits and the configuration registers. When the output transfer stalls, every
// stage holds and the input is not ready, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module phase_current_clarke_park (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // raw_a, raw_b, raw_c, elec_angle
	input  logic [0:0]   s_axis_tuser,   // angle_valid
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,   // i_alpha, i_beta, i_d, i_q, dc_current
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import pcp_pkg::*;

	localparam int LAT    = 33;
	localparam int AL_DLY = 26;
	localparam int DQ_DLY = 9;
	localparam int AV_DLY = 31;
	localparam logic [32:0] ANG_RECIP =
		33'(((64'd1 << 50) / 64'(K_TWO_PI)) + 64'd1);

	logic signed [DATA_W-1:0] off_a_q, off_b_q, off_c_q;
	logic [1:0]               mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_a_q <= '0;
			off_b_q <= '0;
			off_c_q <= '0;
			mode_q  <= MODE_BLDC;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OFFSET_A:    off_a_q <= cfg_wdata;
				REG_OFFSET_B:    off_b_q <= cfg_wdata;
				REG_OFFSET_C:    off_c_q <= cfg_wdata;
				REG_DRIVER_MODE: mode_q  <= cfg_wdata[1:0];
				default:         ;
			endcase
		end
	end

	logic            adv;
	logic [LAT-1:0]  vld_q;

	assign adv           = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	logic signed [DATA_W-1:0] raw_a, raw_b, raw_c, raw_ang;
	assign raw_a   = s_axis_tdata[31:0];
	assign raw_b   = s_axis_tdata[63:32];
	assign raw_c   = s_axis_tdata[95:64];
	assign raw_ang = s_axis_tdata[127:96];

	// Stage 1: offsets and the reciprocal product for the angle quotient.
	logic signed [DATA_W-1:0] a_s1, b_s1, c_s1, ang_s1;
	logic signed [64:0]       angp_s1;
	logic                     av_s1;

	// Stage 2: Clarke case selection, quotient times 2pi.
	logic signed [DATA_W-1:0] pa_s2, pb_s2, sum_s2, ang_s2;
	logic                     common_s2, bldc_s2;
	logic signed [35:0]       qtp_s2;

	// Stage 3: common-mode product, floor remainder of the angle.
	logic signed [49:0]       m_s3;
	logic signed [DATA_W-1:0] pa_s3, pb_s3;
	logic                     common_s3, bldc_s3;
	logic signed [CW-1:0]     r_s3;

	// Stage 4: common-mode removal, fold into the CORDIC range.
	logic signed [DATA_W-1:0] pa_s4, pb_s4;
	logic                     bldc_s4;
	logic signed [CW-1:0]     ra_s4;
	logic                     flip_s4;

	// Stages 5 and 6: beta products and final alpha, beta.
	logic signed [49:0]       p1_s5, p2_s5;
	logic signed [DATA_W-1:0] pa_s5, pb_s5;
	logic                     bldc_s5;
	logic signed [DATA_W-1:0] al_s6, be_s6;

	// Stages 7 and 8: squares, saturated sum of squares.
	logic signed [63:0]       sqa_s7, sqb_s7;
	logic [SUM_W-1:0]         s_s8;

	logic signed [CW-1:0]     cos_s21, sin_s21;
	logic signed [51:0]       pd1_s22, pd2_s22, pq1_s22, pq2_s22;
	logic signed [DATA_W-1:0] d_s23, q_s23;
	logic [ROOT_W-1:0]        root_s32;
	logic [159:0]             out_s33;

	logic signed [DATA_W-1:0] al_dly_q [0:AL_DLY-1];
	logic signed [DATA_W-1:0] be_dly_q [0:AL_DLY-1];
	logic signed [DATA_W-1:0] d_dly_q  [0:DQ_DLY-1];
	logic signed [DATA_W-1:0] q_dly_q  [0:DQ_DLY-1];
	logic                     av_dly_q [0:AV_DLY-1];

	logic signed [DATA_W-1:0] pa_c, pb_c;
	logic                     common_c, bldc_c;
	logic signed [35:0]       r0_c;
	logic signed [CW-1:0]     rr_c;
	logic [47:0]              sa_c, sb_c;
	logic [SUM_W-1:0]         sat_a_c, sat_b_c;
	logic [SUM_W:0]           ssum_c;

	always_comb begin
		pa_c     = a_s1;
		pb_c     = b_s1;
		common_c = 1'b0;
		bldc_c   = 1'b0;
		case (mode_q)
			MODE_STEPPER: ;
			MODE_HYBRID: begin
				if (a_s1 == 0) begin
					pa_c = -c_s1 - b_s1;
				end else if (b_s1 == 0) begin
					pb_c = -c_s1 - a_s1;
				end
			end
			default: begin
				// BLDC and the unused code: a missing phase is rebuilt,
				// otherwise one third of the sum is taken off both phases.
				bldc_c = 1'b1;
				if (c_s1 == 0) begin
				end else if (a_s1 == 0) begin
					pa_c = -c_s1 - b_s1;
				end else if (b_s1 == 0) begin
					pb_c = -a_s1 - c_s1;
				end else begin
					common_c = 1'b1;
				end
			end
		endcase

		// The reciprocal estimate of the quotient is off by at most one.
		r0_c = 36'(ang_s2) - qtp_s2;
		if (r0_c < 0) begin
			r0_c = r0_c + 36'(K_TWO_PI);
		end else if (r0_c >= 36'(K_TWO_PI)) begin
			r0_c = r0_c - 36'(K_TWO_PI);
		end

		rr_c = (r_s3 > K_PI) ? r_s3 - K_TWO_PI : r_s3;

		sa_c    = sqa_s7[63:16];
		sb_c    = sqb_s7[63:16];
		sat_a_c = (sa_c > 48'(MAX_POS)) ? MAX_POS : sa_c[SUM_W-1:0];
		sat_b_c = (sb_c > 48'(MAX_POS)) ? MAX_POS : sb_c[SUM_W-1:0];
		ssum_c  = {1'b0, sat_a_c} + {1'b0, sat_b_c};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= raw_a - off_a_q;
			b_s1    <= raw_b - off_b_q;
			c_s1    <= raw_c - off_c_q;
			ang_s1  <= raw_ang;
			angp_s1 <= 65'(raw_ang) * $signed({32'b0, ANG_RECIP});
			av_s1   <= s_axis_tuser[0];

			pa_s2     <= pa_c;
			pb_s2     <= pb_c;
			sum_s2    <= a_s1 + b_s1 + c_s1;
			common_s2 <= common_c;
			bldc_s2   <= bldc_c;
			ang_s2    <= ang_s1;
			qtp_s2    <= 36'($signed(angp_s1[64:50])) * 36'(K_TWO_PI);

			m_s3      <= 50'(sum_s2) * 50'(K_THIRD);
			pa_s3     <= pa_s2;
			pb_s3     <= pb_s2;
			common_s3 <= common_s2;
			bldc_s3   <= bldc_s2;
			r_s3      <= r0_c[CW-1:0];

			pa_s4   <= common_s3 ? pa_s3 - m_s3[47:16] : pa_s3;
			pb_s4   <= common_s3 ? pb_s3 - m_s3[47:16] : pb_s3;
			bldc_s4 <= bldc_s3;
			if (rr_c > K_HALF_PI) begin
				ra_s4   <= rr_c - K_PI;
				flip_s4 <= 1'b1;
			end else if (rr_c < -K_HALF_PI) begin
				ra_s4   <= rr_c + K_PI;
				flip_s4 <= 1'b1;
			end else begin
				ra_s4   <= rr_c;
				flip_s4 <= 1'b0;
			end

			p1_s5   <= 50'(pa_s4) * 50'(K_INV_SQRT3);
			p2_s5   <= 50'(pb_s4) * 50'(K_TWO_SQRT3);
			pa_s5   <= pa_s4;
			pb_s5   <= pb_s4;
			bldc_s5 <= bldc_s4;

			al_s6 <= pa_s5;
			be_s6 <= bldc_s5 ? p1_s5[47:16] + p2_s5[47:16] : pb_s5;

			sqa_s7 <= 64'(al_s6) * 64'(al_s6);
			sqb_s7 <= 64'(be_s6) * 64'(be_s6);

			s_s8 <= ssum_c[SUM_W] ? MAX_POS : ssum_c[SUM_W-1:0];

			pd1_s22 <= 52'(al_dly_q[14]) * 52'(cos_s21);
			pd2_s22 <= 52'(be_dly_q[14]) * 52'(sin_s21);
			pq1_s22 <= 52'(be_dly_q[14]) * 52'(cos_s21);
			pq2_s22 <= 52'(al_dly_q[14]) * 52'(sin_s21);

			d_s23 <= pd1_s22[47:16] + pd2_s22[47:16];
			q_s23 <= pq1_s22[47:16] - pq2_s22[47:16];

			al_dly_q[0] <= al_s6;
			be_dly_q[0] <= be_s6;
			for (int i = 1; i < AL_DLY; i++) begin
				al_dly_q[i] <= al_dly_q[i-1];
				be_dly_q[i] <= be_dly_q[i-1];
			end
			d_dly_q[0] <= d_s23;
			q_dly_q[0] <= q_s23;
			for (int i = 1; i < DQ_DLY; i++) begin
				d_dly_q[i] <= d_dly_q[i-1];
				q_dly_q[i] <= q_dly_q[i-1];
			end
			av_dly_q[0] <= av_s1;
			for (int i = 1; i < AV_DLY; i++) begin
				av_dly_q[i] <= av_dly_q[i-1];
			end

			// The magnitude is negated when the angle is valid and q is negative or zero.
			out_s33[31:0]    <= al_dly_q[AL_DLY-1];
			out_s33[63:32]   <= be_dly_q[AL_DLY-1];
			out_s33[95:64]   <= d_dly_q[DQ_DLY-1];
			out_s33[127:96]  <= q_dly_q[DQ_DLY-1];
			if (av_dly_q[AV_DLY-1]
					&& (q_dly_q[DQ_DLY-1][DATA_W-1] || q_dly_q[DQ_DLY-1] == 0)) begin
				out_s33[159:128] <= -{{(DATA_W-ROOT_W){1'b0}}, root_s32};
			end else begin
				out_s33[159:128] <= {{(DATA_W-ROOT_W){1'b0}}, root_s32};
			end
		end
	end

	pcp_cordic u_cordic (
		.clk   (clk),
		.en    (adv),
		.ang   (ra_s4),
		.flip  (flip_s4),
		.cos_o (cos_s21),
		.sin_o (sin_s21)
	);

	pcp_sqrt u_sqrt (
		.clk    (clk),
		.en     (adv),
		.s_in   (s_s8),
		.root_o (root_s32)
	);

	assign m_axis_tdata = out_s33;

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_not_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input refused while no result is waiting");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("waiting output transfer changed before it was taken");

	a_unsigned_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_s33[127] == 1'b0) && (out_s33[127:96] != 0)
			|-> !out_s33[159])
		else $error("magnitude negative while q is positive");

endmodule
